// File: rtl/lru_slot_mapper_two_pools_unit_macros.svh
// ----------------------------------------------------------------------------
// LRU slot mapper assertion macros
// Short forms for clocked implications with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef LRU_SLOT_MAPPER_TWO_POOLS_UNIT_MACROS_SVH
`define LRU_SLOT_MAPPER_TWO_POOLS_UNIT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define LSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define LSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lsm_pkg.sv
// ----------------------------------------------------------------------------
// LRU slot mapper package
// Shared constants, command and register codes, and control structs.
// ----------------------------------------------------------------------------
package lsm_pkg;

  // Width of one hardware layer id.
  localparam int unsigned LAYER_W = 3;

  // Default sizes.
  localparam int unsigned MAIN_SLOTS_DEF  = 3;
  localparam int unsigned SUB_SLOTS_DEF   = 4;
  localparam int unsigned SCREEN_ID_W_DEF = 8;

  // Reset values of the layer id registers (slot 0 in the low bits).
  localparam logic [31:0] MAIN_IDS_RESET = 32'd80;
  localparam logic [31:0] SUB_IDS_RESET  = 32'd1672;

  // Configuration register index width.
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [LAYER_W-1:0] lsm_layer_t;

  typedef enum logic [1:0] {
    CMD_SHOW     = 2'd0,
    CMD_REGISTER = 2'd1,
    CMD_CLEAR    = 2'd2
  } lsm_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAIN_IDS = 1'b0,
    CFG_SUB_IDS  = 1'b1
  } lsm_cfg_e;

  // Operation handed to one pool.
  typedef struct packed {
    logic en;     // commit the state update this cycle
    logic clear;  // empty the pool and reload its LRU order
    logic add;    // register a screen in this pool
    logic show;   // show a screen with this pool selected
  } lsm_pool_op_t;

  // Tag lookup result of one pool.
  typedef struct packed {
    logic       hit;
    lsm_layer_t layer;
  } lsm_lookup_t;

  // Result fields of one pool; all zero when the pool is not selected.
  typedef struct packed {
    lsm_layer_t layer;
    logic       was_loaded;
    logic       evicted_valid;
    logic       status;
  } lsm_pool_res_t;

endpackage

// File: rtl/lsm_if.sv
// ----------------------------------------------------------------------------
// LRU slot mapper channels
// Valid/ready request and response interfaces.
// ----------------------------------------------------------------------------
interface lsm_req_if #(
  parameter int unsigned ID_W = 8
);
  logic            valid;
  logic            ready;
  logic [1:0]      command;
  logic [ID_W-1:0] screen_id;
  logic            is_main;

  modport source (output valid, command, screen_id, is_main, input ready);
  modport sink   (input valid, command, screen_id, is_main, output ready);
endinterface

interface lsm_rsp_if #(
  parameter int unsigned ID_W = 8
);
  logic            valid;
  logic            ready;
  logic [2:0]      layer_id;
  logic            was_loaded;
  logic            evicted_valid;
  logic [ID_W-1:0] evicted_screen;
  logic            status;

  modport source (output valid, layer_id, was_loaded, evicted_valid, evicted_screen, status,
                  input ready);
  modport sink   (input valid, layer_id, was_loaded, evicted_valid, evicted_screen, status,
                  output ready);
endinterface

// File: rtl/lsm_pool.sv
// ----------------------------------------------------------------------------
// LRU slot mapper pool
// Tags, fill count and LRU order of one pool, with single-pass update logic.
// ----------------------------------------------------------------------------
module lsm_pool #(
  parameter int unsigned SLOTS = lsm_pkg::MAIN_SLOTS_DEF,
  parameter int unsigned ID_W  = lsm_pkg::SCREEN_ID_W_DEF,
  parameter logic [lsm_pkg::LAYER_W*SLOTS-1:0] RESET_IDS = '0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [lsm_pkg::LAYER_W*SLOTS-1:0] ids_i,
  input  lsm_pkg::lsm_pool_op_t             op_i,
  input  logic [ID_W-1:0]                   sid_i,
  input  lsm_pkg::lsm_lookup_t              other_i,
  output lsm_pkg::lsm_lookup_t              lookup_o,
  output lsm_pkg::lsm_pool_res_t            res_o,
  output logic [ID_W-1:0]                   evicted_o
);
  import lsm_pkg::*;

  localparam int unsigned CW = $clog2(SLOTS + 1);

  logic [ID_W-1:0] tags_q [SLOTS];
  logic [CW-1:0]   count_q, count_d;
  lsm_layer_t      lru_q [SLOTS];
  lsm_layer_t      lru_d [SLOTS];
  lsm_layer_t      slot_layer [SLOTS];

  logic [SLOTS-1:0] fill_oh, vic_oh, wr_oh, pos_oh;
  logic             full, hit, vic_found, pos_found, after, touch;
  lsm_layer_t       hit_layer, fill_layer, vic_layer;
  logic [ID_W-1:0]  vic_tag;
  lsm_pool_res_t    res;
  logic [ID_W-1:0]  evicted;

  // Layer id of each slot from the configuration register.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_layer[i] = ids_i[LAYER_W*i +: LAYER_W];
    end
  end

  // Tag lookup among occupied slots; the lowest matching slot wins.
  always_comb begin
    hit       = 1'b0;
    hit_layer = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (CW'(i) < count_q && tags_q[i] == sid_i) begin
        hit       = 1'b1;
        hit_layer = slot_layer[i];
      end
    end
  end

  assign lookup_o = '{hit: hit, layer: hit_layer};

  // Next free slot and its layer.
  always_comb begin
    full       = (count_q == CW'(SLOTS));
    fill_layer = '0;
    for (int i = 0; i < SLOTS; i++) begin
      fill_oh[i] = (CW'(i) == count_q);
      if (fill_oh[i]) begin
        fill_layer = slot_layer[i];
      end
    end
  end

  // Victim: lowest slot whose layer heads the LRU order, else slot 0.
  always_comb begin
    vic_oh    = '0;
    vic_found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!vic_found && slot_layer[i] == lru_q[0]) begin
        vic_oh[i] = 1'b1;
        vic_found = 1'b1;
      end
    end
    if (!vic_found) begin
      vic_oh[0] = 1'b1;
    end
    vic_layer = '0;
    vic_tag   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (vic_oh[i]) begin
        vic_layer = slot_layer[i];
        vic_tag   = tags_q[i];
      end
    end
  end

  // Request decision: register, show with hit, fill or eviction, or clear.
  always_comb begin
    res     = '0;
    evicted = '0;
    wr_oh   = '0;
    touch   = 1'b0;
    count_d = count_q;
    if (op_i.add) begin
      if (!full) begin
        res.layer = fill_layer;
        wr_oh     = fill_oh;
        count_d   = count_q + CW'(1);
      end else begin
        res.status = 1'b1;
      end
    end else if (op_i.show) begin
      touch = 1'b1;
      if (hit) begin
        res.layer      = hit_layer;
        res.was_loaded = 1'b1;
      end else if (other_i.hit) begin
        res.layer      = other_i.layer;
        res.was_loaded = 1'b1;
      end else if (!full) begin
        res.layer = fill_layer;
        wr_oh     = fill_oh;
        count_d   = count_q + CW'(1);
      end else begin
        res.layer         = vic_layer;
        res.evicted_valid = 1'b1;
        evicted           = vic_tag;
        wr_oh             = vic_oh;
      end
    end else if (op_i.clear) begin
      count_d = '0;
    end
  end

  assign res_o     = res;
  assign evicted_o = evicted;

  // LRU update: move the shown layer to the most-recent end; an absent
  // layer is taken from the head. Clear reloads the order from the slot layers.
  always_comb begin
    pos_oh    = '0;
    pos_found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!pos_found && lru_q[i] == res.layer) begin
        pos_oh[i] = 1'b1;
        pos_found = 1'b1;
      end
    end
    if (!pos_found) begin
      pos_oh[0] = 1'b1;
    end
    after = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      after = after | pos_oh[i];
      if (op_i.clear) begin
        lru_d[i] = slot_layer[i];
      end else if (!touch || !after) begin
        lru_d[i] = lru_q[i];
      end else if (i == SLOTS - 1) begin
        lru_d[i] = res.layer;
      end else begin
        lru_d[i] = lru_q[(i == SLOTS - 1) ? i : i + 1];
      end
    end
  end

  // Fill count and LRU order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        lru_q[i] <= RESET_IDS[LAYER_W*i +: LAYER_W];
      end
    end else if (op_i.en) begin
      count_q <= count_d;
      lru_q   <= lru_d;
    end
  end

  // Tag store; slots above the fill count are never read.
  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (wr_oh[i]) begin
          tags_q[i] <= sid_i;
        end
      end
    end
  end

endmodule

// File: rtl/lru_slot_mapper_two_pools_unit.sv
// ----------------------------------------------------------------------------
// LRU slot mapper, two pools
// Maps screen ids onto configured layer slots of a main and a sub pool.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle unless stalled and returns exactly one
// response for each request: a request is captured in an input register, the
// tag compare, fill, victim choice and LRU update of both pools run in one pass
// from that register, and the outcome lands in a response register while the
// pool state commits at the same edge. Back-pressure on the response side
// stalls the input register and then the request side. The layer id registers
// may be written only while no request is in flight; a write changes slot
// layers at once, while the LRU orders are reloaded from them only by reset
// and by the clear command.
module lru_slot_mapper_two_pools_unit #(
  parameter int unsigned MAIN_SLOTS      = lsm_pkg::MAIN_SLOTS_DEF,
  parameter int unsigned SUB_SLOTS       = lsm_pkg::SUB_SLOTS_DEF,
  parameter int unsigned SCREEN_ID_WIDTH = lsm_pkg::SCREEN_ID_W_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lsm_req_if.sink                          req_i,
  lsm_rsp_if.source                        rsp_o,
  input  logic                             cfg_we_i,
  input  logic [lsm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lsm_pkg::LAYER_W*((MAIN_SLOTS > SUB_SLOTS) ? MAIN_SLOTS : SUB_SLOTS)-1:0]
                                           cfg_data_i
);
  import lsm_pkg::*;

  localparam int unsigned MAIN_W = LAYER_W * MAIN_SLOTS;
  localparam int unsigned SUB_W  = LAYER_W * SUB_SLOTS;

  // Configuration registers.
  logic [MAIN_W-1:0] main_ids_q;
  logic [SUB_W-1:0]  sub_ids_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_ids_q <= MAIN_IDS_RESET[MAIN_W-1:0];
      sub_ids_q  <= SUB_IDS_RESET[SUB_W-1:0];
    end else if (cfg_we_i) begin
      unique case (lsm_cfg_e'(cfg_idx_i))
        CFG_MAIN_IDS: main_ids_q <= cfg_data_i[MAIN_W-1:0];
        CFG_SUB_IDS:  sub_ids_q  <= cfg_data_i[SUB_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic                       inq_valid_q;
  logic [1:0]                 cmd_q;
  logic [SCREEN_ID_WIDTH-1:0] sid_q;
  logic                       is_main_q;
  logic                       rsp_valid_q;
  logic                       advance;

  assign advance     = inq_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !inq_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      inq_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      cmd_q     <= req_i.command;
      sid_q     <= req_i.screen_id;
      is_main_q <= req_i.is_main;
    end
  end

  // Command decode into per-pool operations.
  lsm_pool_op_t main_op, sub_op;

  always_comb begin
    main_op    = '0;
    sub_op     = '0;
    main_op.en = advance;
    sub_op.en  = advance;
    unique case (cmd_q)
      CMD_SHOW: begin
        main_op.show = is_main_q;
        sub_op.show  = !is_main_q;
      end
      CMD_REGISTER: begin
        main_op.add = is_main_q;
        sub_op.add  = !is_main_q;
      end
      CMD_CLEAR: begin
        main_op.clear = 1'b1;
        sub_op.clear  = 1'b1;
      end
      default: ;
    endcase
  end

  // The two pools; each sees the other's lookup for cross-pool hits.
  lsm_lookup_t                main_look, sub_look;
  lsm_pool_res_t              main_res, sub_res;
  logic [SCREEN_ID_WIDTH-1:0] main_evicted, sub_evicted;

  lsm_pool #(
    .SLOTS     (MAIN_SLOTS),
    .ID_W      (SCREEN_ID_WIDTH),
    .RESET_IDS (MAIN_IDS_RESET[MAIN_W-1:0])
  ) u_main_pool (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ids_i     (main_ids_q),
    .op_i      (main_op),
    .sid_i     (sid_q),
    .other_i   (sub_look),
    .lookup_o  (main_look),
    .res_o     (main_res),
    .evicted_o (main_evicted)
  );

  lsm_pool #(
    .SLOTS     (SUB_SLOTS),
    .ID_W      (SCREEN_ID_WIDTH),
    .RESET_IDS (SUB_IDS_RESET[SUB_W-1:0])
  ) u_sub_pool (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ids_i     (sub_ids_q),
    .op_i      (sub_op),
    .sid_i     (sid_q),
    .other_i   (main_look),
    .lookup_o  (sub_look),
    .res_o     (sub_res),
    .evicted_o (sub_evicted)
  );

  // Response register; an unselected pool reports all zeros.
  lsm_pool_res_t              rsp_res_q;
  logic [SCREEN_ID_WIDTH-1:0] rsp_evicted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_res_q     <= main_res | sub_res;
      rsp_evicted_q <= main_evicted | sub_evicted;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.layer_id       = rsp_res_q.layer;
  assign rsp_o.was_loaded     = rsp_res_q.was_loaded;
  assign rsp_o.evicted_valid  = rsp_res_q.evicted_valid;
  assign rsp_o.evicted_screen = rsp_evicted_q;
  assign rsp_o.status         = rsp_res_q.status;

endmodule

// File: rtl/lsm_checker.sv
// ----------------------------------------------------------------------------
// LRU slot mapper checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru_slot_mapper_two_pools_unit_macros.svh"

module lsm_checker #(
  parameter int unsigned ID_W = 8
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input logic [2:0]      rsp_layer_id_i,
  input logic            rsp_was_loaded_i,
  input logic            rsp_evicted_valid_i,
  input logic [ID_W-1:0] rsp_evicted_screen_i,
  input logic            rsp_status_i
);

  // A stalled response stays offered.
  `LSM_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "response dropped while stalled")

  // No evicted screen id is reported without an eviction.
  `LSM_ASSERT_IMP(a_evict_zero, clk_i, rst_ni, rsp_valid_i && !rsp_evicted_valid_i, rsp_evicted_screen_i == '0, "evicted screen without eviction")

  // A refused register reports nothing else.
  `LSM_ASSERT_IMP(a_refused_clean, clk_i, rst_ni, rsp_valid_i && rsp_status_i, rsp_layer_id_i == 3'd0 && !rsp_was_loaded_i && !rsp_evicted_valid_i, "refused register with extra fields")

  // A screen found loaded never causes an eviction.
  `LSM_ASSERT_IMP(a_hit_no_evict, clk_i, rst_ni, rsp_valid_i && rsp_was_loaded_i, !rsp_evicted_valid_i, "eviction on a hit")

endmodule

bind lru_slot_mapper_two_pools_unit lsm_checker #(
  .ID_W (SCREEN_ID_WIDTH)
) u_lsm_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .rsp_valid_i          (rsp_o.valid),
  .rsp_ready_i          (rsp_o.ready),
  .rsp_layer_id_i       (rsp_o.layer_id),
  .rsp_was_loaded_i     (rsp_o.was_loaded),
  .rsp_evicted_valid_i  (rsp_o.evicted_valid),
  .rsp_evicted_screen_i (rsp_o.evicted_screen),
  .rsp_status_i         (rsp_o.status)
);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the two-pool LRU slot mapper
// Drives show, register, clear and unused requests with random gaps and response
// stalls, predicts each response from a model of the pools and their LRU
// orders, and compares every response field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lsm_pkg::*;

  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned LONG_HOLD   = 48;
  localparam int unsigned PHASE_ITEMS = 90;
  localparam int unsigned NUM_PHASES  = 5;
  localparam int unsigned DRAIN_WAIT  = 8;

  // Command code that the block has to ignore.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One response of the block.
  typedef struct packed {
    lsm_layer_t layer_id;
    logic       was_loaded;
    logic       evicted_valid;
    logic [7:0] evicted_screen;
    logic       status;
  } screen_map_t;

  // Model of both pools and the queue of responses still to come.
  class slot_map_tracker;
    localparam int unsigned MAIN_N = 3;
    localparam int unsigned SUB_N  = 4;

    logic [8:0]    main_ids;
    logic [11:0]   sub_ids;
    logic [7:0]    tags [2][4];   // pool 0 is sub, pool 1 is main
    int unsigned   count [2];
    lsm_layer_t    lru [2][4];    // least recent first
    screen_map_t   expected_q [$];
    int unsigned   errors;

    function new();
      errors = 0;
      main_ids = MAIN_IDS_RESET[8:0];
      sub_ids = SUB_IDS_RESET[11:0];
      for (int p = 0; p < 2; p++) begin
        for (int s = 0; s < 4; s++) tags[p][s] = '0;
        empty_pool(p);
      end
    endfunction

    function int unsigned depth(int unsigned p);
      return (p == 1) ? MAIN_N : SUB_N;
    endfunction

    function lsm_layer_t slot_layer(int unsigned p, int unsigned s);
      logic [11:0] ids;
      ids = (p == 1) ? {3'b000, main_ids} : sub_ids;
      return ids[3*s +: 3];
    endfunction

    function void empty_pool(int unsigned p);
      count[p] = 0;
      for (int unsigned i = 0; i < depth(p); i++) lru[p][i] = slot_layer(p, i);
    endfunction

    function void set_register(lsm_cfg_e idx, logic [11:0] data);
      if (idx == CFG_MAIN_IDS) main_ids = data[8:0];
      else sub_ids = data;
    endfunction

    // Move a layer to the most-recent end; a missing layer counts as the head.
    function void touch(int unsigned p, lsm_layer_t layer);
      int unsigned pos;
      bit          found;
      pos = 0;
      found = 0;
      for (int unsigned i = 0; i < depth(p); i++) begin
        if (!found && lru[p][i] == layer) begin
          pos = i;
          found = 1;
        end
      end
      for (int unsigned i = pos; i + 1 < depth(p); i++) lru[p][i] = lru[p][i+1];
      lru[p][depth(p)-1] = layer;
    endfunction

    function bit lookup(int unsigned p, logic [7:0] sid, output lsm_layer_t layer);
      layer = '0;
      for (int unsigned i = 0; i < count[p]; i++) begin
        if (tags[p][i] == sid) begin
          layer = slot_layer(p, i);
          return 1;
        end
      end
      return 0;
    endfunction

    // Apply one request to the pools and return the response it must cause.
    function screen_map_t map_screen(logic [1:0] cmd, logic [7:0] sid, logic is_main);
      screen_map_t r;
      int unsigned p;
      int unsigned victim;
      bit          hit;
      bit          found;
      lsm_layer_t  layer;
      r = '0;
      p = is_main;
      case (cmd)
        CMD_CLEAR: begin
          empty_pool(0);
          empty_pool(1);
        end
        CMD_REGISTER: begin
          if (count[p] < depth(p)) begin
            r.layer_id = slot_layer(p, count[p]);
            tags[p][count[p]] = sid;
            count[p]++;
          end else begin
            r.status = 1'b1;
          end
        end
        CMD_SHOW: begin
          hit = lookup(p, sid, layer);
          if (!hit) hit = lookup(p ^ 1, sid, layer);
          if (hit) begin
            r.was_loaded = 1'b1;
            r.layer_id = layer;
          end else if (count[p] < depth(p)) begin
            r.layer_id = slot_layer(p, count[p]);
            tags[p][count[p]] = sid;
            count[p]++;
          end else begin
            // Evict the lowest slot whose layer heads the LRU order, else slot 0.
            victim = 0;
            found = 0;
            for (int unsigned i = 0; i < depth(p); i++) begin
              if (!found && slot_layer(p, i) == lru[p][0]) begin
                victim = i;
                found = 1;
              end
            end
            r.evicted_valid = 1'b1;
            r.evicted_screen = tags[p][victim];
            tags[p][victim] = sid;
            r.layer_id = slot_layer(p, victim);
          end
          touch(p, r.layer_id);
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(logic [1:0] cmd, logic [7:0] sid, logic is_main);
      expected_q.push_back(map_screen(cmd, sid, is_main));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void check_response(screen_map_t got);
      screen_map_t want;
      if (expected_q.size() == 0) begin
        $error("response with no request waiting: layer_id %0d", got.layer_id);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.layer_id !== want.layer_id) begin
        $error("layer_id: expected %0d, actual %0d", want.layer_id, got.layer_id);
        errors++;
      end
      if (got.was_loaded !== want.was_loaded) begin
        $error("was_loaded: expected %0d, actual %0d", want.was_loaded, got.was_loaded);
        errors++;
      end
      if (got.evicted_valid !== want.evicted_valid) begin
        $error("evicted_valid: expected %0d, actual %0d", want.evicted_valid,
               got.evicted_valid);
        errors++;
      end
      if (got.evicted_screen !== want.evicted_screen) begin
        $error("evicted_screen: expected %0d, actual %0d", want.evicted_screen,
               got.evicted_screen);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [11:0] cfg_data_i;

  lsm_req_if #(.ID_W(8)) req_if ();
  lsm_rsp_if #(.ID_W(8)) rsp_if ();

  slot_map_tracker tracker;
  bit              gaps_on;
  bit              rsp_hold_req;
  int unsigned     cycle_count;

  lru_slot_mapper_two_pools_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock.
  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Offer one request, optionally after a gap, and wait until it is taken.
  task automatic send_request(logic [1:0] cmd, logic [7:0] sid, logic is_main);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.screen_id <= sid;
    req_if.is_main <= is_main;
    do @(posedge clk_i); while (!req_if.ready);
    tracker.note_request(cmd, sid, is_main);
  endtask

  // Mostly shows and registers over a few screen ids, so that hits and
  // evictions are common; now and then a clear or an unused command.
  task automatic send_random_request();
    int unsigned pick;
    logic [1:0]  cmd;
    logic [7:0]  sid;
    pick = $urandom_range(0, 99);
    if (pick < 62) cmd = CMD_SHOW;
    else if (pick < 90) cmd = CMD_REGISTER;
    else if (pick < 97) cmd = CMD_CLEAR;
    else cmd = CMD_UNUSED;
    if ($urandom_range(0, 3) != 0) sid = 8'($urandom_range(0, 11));
    else sid = 8'($urandom_range(0, 255));
    send_request(cmd, sid, 1'($urandom_range(0, 1)));
  endtask

  // Stop offering requests and wait for every response to come back.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // One register write, after which the write port is left idle.
  task automatic write_register(lsm_cfg_e idx, logic [11:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.set_register(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Response side: random stall bursts, plus one long hold on request.
  initial begin
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (gaps_on && $urandom_range(0, 2) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  // Check every accepted response.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      tracker.check_response('{layer_id: rsp_if.layer_id, was_loaded: rsp_if.was_loaded,
                               evicted_valid: rsp_if.evicted_valid,
                               evicted_screen: rsp_if.evicted_screen,
                               status: rsp_if.status});
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Stimulus.
  initial begin
    logic [11:0] main_cfg [NUM_PHASES];
    logic [11:0] sub_cfg [NUM_PHASES];

    tracker = new();
    gaps_on = 1'b1;
    rsp_hold_req = 1'b0;
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.command <= CMD_SHOW;
    req_if.screen_id <= '0;
    req_if.is_main <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_MAIN_IDS;
    cfg_data_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests with the reset layer ids.
    send_request(CMD_UNUSED, 8'hFF, 1'b1);
    send_request(CMD_SHOW, 8'h00, 1'b1);
    send_request(CMD_REGISTER, 8'hFF, 1'b1);
    send_request(CMD_REGISTER, 8'hFF, 1'b1);    // same screen in a second slot
    send_request(CMD_REGISTER, 8'h10, 1'b1);    // main pool full, refused
    send_request(CMD_SHOW, 8'h20, 1'b1);        // eviction by LRU head
    send_request(CMD_SHOW, 8'hFF, 1'b1);
    send_request(CMD_SHOW, 8'h00, 1'b0);        // found in the other pool
    send_request(CMD_SHOW, 8'hFF, 1'b0);
    send_request(CMD_REGISTER, 8'h00, 1'b0);
    send_request(CMD_SHOW, 8'h00, 1'b1);        // selected pool searched first
    send_request(CMD_SHOW, 8'h00, 1'b0);
    send_request(CMD_REGISTER, 8'h01, 1'b0);
    send_request(CMD_REGISTER, 8'h02, 1'b0);
    send_request(CMD_REGISTER, 8'h03, 1'b0);
    send_request(CMD_REGISTER, 8'h04, 1'b0);    // sub pool full, refused
    send_request(CMD_SHOW, 8'hAA, 1'b0);
    send_request(CMD_CLEAR, 8'h00, 1'b0);
    send_request(CMD_SHOW, 8'hFF, 1'b0);
    send_request(CMD_UNUSED, 8'h5A, 1'b0);
    drain();

    // Duplicate layer ids and stale LRU orders with layers that match no slot layer.
    write_register(CFG_MAIN_IDS, 12'hFFF);
    write_register(CFG_SUB_IDS, 12'h000);
    send_request(CMD_SHOW, 8'h11, 1'b1);
    send_request(CMD_SHOW, 8'h22, 1'b1);
    send_request(CMD_SHOW, 8'h33, 1'b1);
    send_request(CMD_SHOW, 8'h44, 1'b1);
    send_request(CMD_SHOW, 8'h22, 1'b0);        // layer absent from sub order
    send_request(CMD_REGISTER, 8'h05, 1'b0);
    send_request(CMD_SHOW, 8'h05, 1'b1);
    drain();

    // Random phases, each with its own layer ids; the last one runs without gaps.
    main_cfg[0] = 12'h000;
    sub_cfg[0] = 12'hFFF;
    main_cfg[1] = 12'($urandom_range(0, 4095));
    sub_cfg[1] = 12'($urandom_range(0, 4095));
    main_cfg[2] = 12'h1FF;
    sub_cfg[2] = 12'h000;
    main_cfg[3] = 12'($urandom_range(0, 4095));
    sub_cfg[3] = 12'($urandom_range(0, 4095));
    main_cfg[4] = MAIN_IDS_RESET[11:0];
    sub_cfg[4] = SUB_IDS_RESET[11:0];
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_register(CFG_MAIN_IDS, main_cfg[ph]);
      write_register(CFG_SUB_IDS, sub_cfg[ph]);
      gaps_on = (ph < NUM_PHASES - 1);
      if (ph == 1) rsp_hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_request();
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: lru_slot_mapper_two_pools_unit.f
+incdir+rtl
rtl/lsm_pkg.sv
rtl/lsm_if.sv
rtl/lsm_pool.sv
rtl/lru_slot_mapper_two_pools_unit.sv
rtl/lsm_checker.sv
tb/sv/tb_top.sv
